[sv/ffa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, opcodes, result codes and parameter defaults
// for the first-free unit allocator. No dependencies.
package ffa_pkg;

   localparam int DEF_UNITS       = 8;
   localparam int DEF_QUEUE_DEPTH = 16;

   localparam logic [1:0] OP_BOOK = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_SHUT = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [2:0] EV_ALLOC    = 3'd0;
   localparam logic [2:0] EV_QUEUED   = 3'd1;
   localparam logic [2:0] EV_REJECT   = 3'd2;
   localparam logic [2:0] EV_IGNORED  = 3'd3;
   localparam logic [2:0] EV_FINISH   = 3'd4;
   localparam logic [2:0] EV_DISPATCH = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] user;
      logic [7:0]  wing;
      logic [15:0] dur;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   typedef struct packed {
      logic [2:0]  ev;
      logic [2:0]  unit;
      logic [15:0] user;
      logic [7:0]  wing;
      logic [15:0] dur;
      logic [31:0] seq;
      logic        last;
   } rsp_type;

endpackage

[sv/ffa_front.sv]
`timescale 1ns / 1ps
// Front end: classifies an incoming beat and normalizes its duration.
// Depends on ffa_pkg.
module ffa_front (
   input  logic [1:0]       kind,
   input  logic [15:0]      user_id,
   input  logic [7:0]       wing_tag,
   input  logic [15:0]      duration,
   output ffa_pkg::item_type item
);

   always_comb begin
      item.user = user_id;
      item.wing = wing_tag;
      item.dur  = (duration == 16'd0) ? 16'd1 : duration;
      unique case (kind)
         2'd0: item.op = ffa_pkg::OP_BOOK;
         2'd1: item.op = ffa_pkg::OP_TICK;
         2'd2: item.op = ffa_pkg::OP_SHUT;
         2'd3: item.op = ffa_pkg::OP_NONE;
      endcase
   end

endmodule

[sv/ffa_itemq.sv]
`timescale 1ns / 1ps
// Two-entry item queue between the front end and the allocation engine.
// Depends on ffa_pkg.
module ffa_itemq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ffa_pkg::item_type in_item,
   output ffa_pkg::link_type link,
   input  logic              pop
);

   ffa_pkg::item_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready   = (cnt_ff != 2'd2);
   assign push       = in_valid && in_ready;
   assign link.valid = (cnt_ff != 2'd0);
   assign link.item  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= in_item;
      end
   end

endmodule

[sv/ffa_back.sv]
`timescale 1ns / 1ps
// Allocation engine: unit table, wait-queue memory, tick walk and result register.
// Depends on ffa_pkg.
module ffa_back #(
   parameter int UNITS       = ffa_pkg::DEF_UNITS,
   parameter int QUEUE_DEPTH = ffa_pkg::DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  ffa_pkg::link_type link,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffa_pkg::rsp_type  rsp
);

   localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BOOK = 3'd1;
   localparam logic [2:0] S_TICK = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_DISP = 3'd5;

   typedef struct packed {
      logic [15:0] user;
      logic [7:0]  wing;
      logic [15:0] dur;
      logic [31:0] seq;
   } qent_type;

   logic [2:0]        state_ff, state_in;
   logic [UNITS-1:0]  busy_ff, busy_in;
   logic [15:0]       rem_ff [UNITS];
   logic [15:0]       rem_in [UNITS];
   logic [15:0]       user_ff [UNITS];
   logic [15:0]       user_in [UNITS];
   logic [7:0]        wing_ff [UNITS];
   logic [7:0]        wing_in [UNITS];
   logic [QW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [31:0]       seq_ff, seq_in;
   logic              shut_ff, shut_in;
   logic [UNITS-1:0]  fin_ff, fin_in;
   logic [UW-1:0]     idx_ff, idx_in;
   ffa_pkg::item_type cur_ff, cur_in;
   ffa_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   qent_type          queue_mem_ff [QUEUE_DEPTH];
   qent_type          rd_ff;
   qent_type          wdata;
   logic              we;
   logic [QW-1:0]     tail;
   logic [QW:0]       tail_sum;
   logic [QW-1:0]     head_next;

   logic              emit_ok;
   logic              emit;
   logic              free_any;
   logic [UW-1:0]     free_idx;
   logic [UW-1:0]     fin_idx;
   logic [UNITS-1:0]  tick_fin;
   logic [UNITS-1:0]  rest;
   logic              disp;

   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign free_any  = ~&busy_ff;
   assign rest      = fin_ff & ~(UNITS'(1) << fin_idx);
   assign disp      = !shut_ff && (count_ff != CW'(0));

   assign tail_sum  = {1'b0, head_ff} + (QW + 1)'(count_ff);
   assign tail      = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign head_next = (head_ff == QW'(QUEUE_DEPTH - 1)) ? QW'(0) : head_ff + QW'(1);

   always_comb begin
      free_idx = UW'(0);
      fin_idx  = UW'(0);
      for (int i = UNITS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = UW'(i);
         end
         if (fin_ff[i]) begin
            fin_idx = UW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < UNITS; i++) begin
         tick_fin[i] = busy_ff[i] && (rem_ff[i] <= 16'd1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      user_in      = user_ff;
      wing_in      = wing_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      seq_in       = seq_ff;
      shut_in      = shut_ff;
      fin_in       = fin_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      we           = 1'b0;
      wdata.user   = cur_ff.user;
      wdata.wing   = cur_ff.wing;
      wdata.dur    = cur_ff.dur;
      wdata.seq    = seq_ff;
      case (state_ff)
         S_IDLE: begin
            if (link.valid) begin
               pop    = 1'b1;
               cur_in = link.item;
               unique case (link.item.op)
                  ffa_pkg::OP_BOOK: state_in = S_BOOK;
                  ffa_pkg::OP_TICK: state_in = S_TICK;
                  ffa_pkg::OP_SHUT: shut_in  = 1'b1;
                  ffa_pkg::OP_NONE: state_in = S_IDLE;
               endcase
            end
         end
         S_BOOK: begin
            if (emit_ok) begin
               emit        = 1'b1;
               rsp_in.unit = 3'd0;
               rsp_in.user = cur_ff.user;
               rsp_in.wing = cur_ff.wing;
               rsp_in.dur  = cur_ff.dur;
               rsp_in.seq  = 32'd0;
               rsp_in.last = 1'b1;
               priority if (shut_ff) begin
                  rsp_in.ev = ffa_pkg::EV_IGNORED;
               end else if (free_any) begin
                  rsp_in.ev         = ffa_pkg::EV_ALLOC;
                  rsp_in.unit       = 3'(free_idx);
                  busy_in[free_idx] = 1'b1;
                  rem_in[free_idx]  = cur_ff.dur;
                  user_in[free_idx] = cur_ff.user;
                  wing_in[free_idx] = cur_ff.wing;
               end else if (count_ff != CW'(QUEUE_DEPTH)) begin
                  rsp_in.ev  = ffa_pkg::EV_QUEUED;
                  rsp_in.seq = seq_ff;
                  we         = 1'b1;
                  seq_in     = seq_ff + 32'd1;
                  count_in   = count_ff + CW'(1);
               end else begin
                  rsp_in.ev = ffa_pkg::EV_REJECT;
               end
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            for (int i = 0; i < UNITS; i++) begin
               if (tick_fin[i]) begin
                  busy_in[i] = 1'b0;
                  rem_in[i]  = 16'd0;
               end else if (busy_ff[i]) begin
                  rem_in[i] = rem_ff[i] - 16'd1;
               end
            end
            fin_in   = tick_fin;
            state_in = (tick_fin != '0) ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (emit_ok) begin
               emit        = 1'b1;
               rsp_in.ev   = ffa_pkg::EV_FINISH;
               rsp_in.unit = 3'(fin_idx);
               rsp_in.user = user_ff[fin_idx];
               rsp_in.wing = wing_ff[fin_idx];
               rsp_in.dur  = 16'd0;
               rsp_in.seq  = 32'd0;
               rsp_in.last = !disp && (rest == '0);
               fin_in      = rest;
               idx_in      = fin_idx;
               priority if (disp) begin
                  state_in = S_RD;
               end else if (rest == '0) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_RD: begin
            state_in = S_DISP;
         end
         S_DISP: begin
            if (emit_ok) begin
               emit            = 1'b1;
               rsp_in.ev       = ffa_pkg::EV_DISPATCH;
               rsp_in.unit     = 3'(idx_ff);
               rsp_in.user     = rd_ff.user;
               rsp_in.wing     = rd_ff.wing;
               rsp_in.dur      = rd_ff.dur;
               rsp_in.seq      = rd_ff.seq;
               rsp_in.last     = (fin_ff == '0);
               busy_in[idx_ff] = 1'b1;
               rem_in[idx_ff]  = rd_ff.dur;
               user_in[idx_ff] = rd_ff.user;
               wing_in[idx_ff] = rd_ff.wing;
               head_in         = head_next;
               count_in        = count_ff - CW'(1);
               state_in        = (fin_ff == '0) ? S_IDLE : S_FIN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         seq_ff       <= 32'd0;
         shut_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         shut_ff      <= shut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      user_ff <= user_in;
      wing_ff <= wing_in;
      fin_ff  <= fin_in;
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         queue_mem_ff[tail] <= wdata;
      end
      rd_ff <= queue_mem_ff[head_ff];
   end

endmodule

[sv/first_free_unit_allocator_fifo_top.sv]
`timescale 1ns / 1ps
// A book beat passes the item queue, the current-item register and the book state into the
// result register. Steps per beat (engine sequencer): book pops, books; shutdown pops; tick
// pops, walks, a finish per finishing unit, per dispatch a registered queue read and dispatch.
// A two-entry item queue takes new beats while the engine works or a result waits.
// Reset (synchronous): all units free, wait queue empty, sequence zero, shutdown cleared;
// the wait-queue memory is not cleared, only live entries are read.
module first_free_unit_allocator_fifo_top #(
   parameter int UNITS       = ffa_pkg::DEF_UNITS,
   parameter int QUEUE_DEPTH = ffa_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_user_id,
   input  logic [7:0]  req_wing_tag,
   input  logic [15:0] req_duration,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [2:0]  rsp_unit_index,
   output logic [15:0] rsp_job_user,
   output logic [7:0]  rsp_job_wing,
   output logic [15:0] rsp_job_duration,
   output logic [31:0] rsp_job_seq,
   output logic        rsp_last
);

   ffa_pkg::item_type item;
   ffa_pkg::link_type link;
   ffa_pkg::rsp_type  rsp;
   logic              pop;

   ffa_front u_front (
      .kind     (req_kind),
      .user_id  (req_user_id),
      .wing_tag (req_wing_tag),
      .duration (req_duration),
      .item     (item)
   );

   ffa_itemq u_itemq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (item),
      .link     (link),
      .pop      (pop)
   );

   ffa_back #(
      .UNITS       (UNITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .link      (link),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_event_res    = rsp.ev;
   assign rsp_unit_index   = rsp.unit;
   assign rsp_job_user     = rsp.user;
   assign rsp_job_wing     = rsp.wing;
   assign rsp_job_duration = rsp.dur;
   assign rsp_job_seq      = rsp.seq;
   assign rsp_last         = rsp.last;

`ifndef SYNTHESIS
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> link.valid)
      else $error("engine popped an empty item queue");

   a_full_means_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> link.valid)
      else $error("item queue full but no item offered to engine");

   a_book_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == ffa_pkg::EV_ALLOC || rsp_event_res == ffa_pkg::EV_QUEUED ||
      rsp_event_res == ffa_pkg::EV_REJECT || rsp_event_res == ffa_pkg::EV_IGNORED) |-> rsp_last)
      else $error("book result not marked last");

   a_finish_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ffa_pkg::EV_FINISH |->
      rsp_job_duration == 16'd0 && rsp_job_seq == 32'd0)
      else $error("finish beat carries duration or sequence");
`endif

endmodule
